### rtl/i2cram_pkg.sv
// i2cram_pkg: shared types and constants of the i2c register access master
// used by the register file, the sequencer and the top level
package i2cram_pkg;

	localparam int APB_ADDR_W = 4;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_UNIT_TICKS     = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;

	localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd208;
	localparam logic [15:0] RST_UNIT_TICKS     = 16'd1;
	localparam logic [7:0]  RST_ACK_TIMEOUT    = 8'd200;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// sequence stages, upper three bits of the step
	localparam logic [2:0] STG_IDLE    = 3'd0;
	localparam logic [2:0] STG_START   = 3'd1;
	localparam logic [2:0] STG_BYTE0   = 3'd2;
	localparam logic [2:0] STG_BYTE1   = 3'd3;
	localparam logic [2:0] STG_BYTE2   = 3'd4;
	localparam logic [2:0] STG_RESTART = 3'd5;
	localparam logic [2:0] STG_RX      = 3'd6;
	localparam logic [2:0] STG_STOP    = 3'd7;

	localparam logic [5:0] STEP_IDLE    = {STG_IDLE, 3'd0};
	localparam logic [5:0] STEP_START   = {STG_START, 3'd0};
	localparam logic [5:0] STEP_BYTE0   = {STG_BYTE0, 3'd0};
	localparam logic [5:0] STEP_BYTE1   = {STG_BYTE1, 3'd0};
	localparam logic [5:0] STEP_BYTE2   = {STG_BYTE2, 3'd0};
	localparam logic [5:0] STEP_RESTART = {STG_RESTART, 3'd0};
	localparam logic [5:0] STEP_RX      = {STG_RX, 3'd0};
	localparam logic [5:0] STEP_STOP    = {STG_STOP, 3'd0};
	localparam logic [5:0] STEP_RX_SAMPLE = {STG_RX, 3'd2};

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [15:0] unit_ticks;
		logic [7:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       sda_sampled;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_missing;
	} result_t;

endpackage

### rtl/i2cram_req_if.sv
// i2cram_req_if: input channel carrying ticks and commands
// depends on nothing
interface i2cram_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] reg_address;
	logic [7:0] write_data;
	logic       sda_sampled;

	modport source (output valid, kind, reg_address, write_data, sda_sampled, input ready);
	modport sink (input valid, kind, reg_address, write_data, sda_sampled, output ready);
endinterface

### rtl/i2cram_rsp_if.sv
// i2cram_rsp_if: result channel carrying pin levels and status
// depends on nothing
interface i2cram_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_pull_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       ack_missing;

	modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
		ack_missing, input ready);
	modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
		ack_missing, output ready);
endinterface

### rtl/i2c_register_access_master.sv
// i2c_register_access_master: top level of the pin-level i2c register master
// depends on i2cram_pkg, i2cram_req_if, i2cram_rsp_if, i2cram_regs, i2cram_seq
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      kind, reg_address, write_data, sda_sampled
//   rsp      out  valid/ready      scl_level, sda_pull_low, busy_res, done_res,
//                                  read_byte, ack_missing
//   apb      in   psel/penable     device_address, unit_ticks, ack_timeout
//
// one transaction per clock while rsp is not stalled: an accepted item is held in the
// input register, the sequencer updates its state from it and the result is registered
// in the output register together with the sequencer state; the output register drives
// rsp.valid and the result fields
// the combinational sequencer update between the two registers sets the rate; nothing iterates
// arst_n clears the sequencer to idle and both channel registers to empty
// a stalled rsp holds the output register; the input register then holds its item
// and req.ready drops until rsp drains
module i2c_register_access_master import i2cram_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	i2cram_req_if.sink            req,
	i2cram_rsp_if.source          rsp
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    res_valid_q;
	logic    out_free;
	logic    step_en;

	// configuration registers
	i2cram_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// output slot is free when empty or being taken this cycle
	assign out_free  = ~res_valid_q | rsp.ready;
	assign step_en   = valid_s1 & out_free;
	assign req.ready = ~valid_s1 | step_en;

	// valid flags of the input and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (out_free) res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind        <= req.kind;
			item_s1.reg_address <= req.reg_address;
			item_s1.write_data  <= req.write_data;
			item_s1.sda_sampled <= req.sda_sampled;
		end
		if (step_en) res_q <= res_d;
	end

	// sequencer, advanced once per item
	i2cram_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (step_en),
		.item    (item_s1),
		.res     (res_d)
	);

	// result register to the rsp channel
	assign rsp.valid        = res_valid_q;
	assign rsp.scl_level    = res_q.scl_level;
	assign rsp.sda_pull_low = res_q.sda_pull_low;
	assign rsp.busy_res     = res_q.busy_res;
	assign rsp.done_res     = res_q.done_res;
	assign rsp.read_byte    = res_q.read_byte;
	assign rsp.ack_missing  = res_q.ack_missing;

endmodule

### rtl/i2cram_regs.sv
// i2cram_regs: apb configuration registers
// depends on i2cram_pkg
module i2cram_regs import i2cram_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= RST_DEVICE_ADDRESS;
			cfg_q.unit_ticks     <= RST_UNIT_TICKS;
			cfg_q.ack_timeout    <= RST_ACK_TIMEOUT;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DEVICE_ADDRESS: cfg_q.device_address <= pwdata[7:0];
				REG_UNIT_TICKS:     cfg_q.unit_ticks     <= pwdata[15:0];
				REG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_q.device_address};
			REG_UNIT_TICKS:     prdata = {16'd0, cfg_q.unit_ticks};
			REG_ACK_TIMEOUT:    prdata = {24'd0, cfg_q.ack_timeout};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/i2cram_seq.sv
// i2cram_seq: pin-level sequencer state and its one-item update
// depends on i2cram_pkg
module i2cram_seq import i2cram_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step_en,
	input  item_t   item,
	output result_t res
);

	typedef struct packed {
		logic       scl;
		logic       low;
		logic [2:0] units;
	} levels_t;

	logic [5:0]  step_q, step_n;
	logic [3:0]  bit_q, bit_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] dly_q, dly_n;
	logic [7:0]  cnt_q, cnt_n;
	logic        is_read_q, is_read_n;
	logic [7:0]  reg_q, reg_n;
	logic [7:0]  data_q, data_n;
	logic [7:0]  recv_q, recv_n;
	logic        err_q, err_n;

	function automatic levels_t step_levels(input logic [5:0] step, input logic msb);
		levels_t    lv;
		logic [2:0] stg;
		logic [2:0] seg;
		stg = step[5:3];
		seg = step[2:0];
		lv.scl   = 1'b1;
		lv.low   = 1'b0;
		lv.units = 3'd1;
		case (stg)
			STG_START, STG_RESTART: begin
				if (seg <= 3'd1) begin
					lv.low   = seg[0];
					lv.units = 3'd4;
				end
			end
			STG_BYTE0, STG_BYTE1, STG_BYTE2: begin
				lv.scl = 1'b0;
				if (seg <= 3'd2) begin
					lv.scl   = (seg == 3'd1);
					lv.low   = ~msb;
					lv.units = 3'd2;
				end else if (seg == 3'd3) begin
					lv.units = 3'd3;
				end else if (seg == 3'd4) begin
					lv.units = 3'd0;
				end else begin
					lv.scl = (seg == 3'd6);
				end
			end
			STG_RX: begin
				lv.scl   = (seg == 3'd2);
				lv.units = (seg == 3'd1) ? 3'd2 : 3'd1;
			end
			STG_STOP: begin
				lv.scl   = (seg != 3'd0);
				lv.low   = (seg != 3'd2);
				lv.units = 3'd4;
			end
			default: ;
		endcase
		return lv;
	endfunction

	levels_t     lv;
	logic        cmd;
	logic        do_adv;
	logic        do_after;
	logic        fin;
	logic [5:0]  cur_step;
	logic [15:0] per_unit;
	logic [16:0] dly_inc;
	logic [7:0]  cnt_inc;
	logic [3:0]  bit_inc;
	logic [2:0]  stg_q;
	logic [2:0]  seg_q;

	assign stg_q    = step_q[5:3];
	assign seg_q    = step_q[2:0];
	assign per_unit = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
	assign dly_inc  = {1'b0, dly_q} + 17'd1;
	assign cnt_inc  = cnt_q + 8'd1;
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		step_n    = step_q;
		bit_n     = bit_q;
		shift_n   = shift_q;
		dly_n     = dly_q;
		cnt_n     = cnt_q;
		is_read_n = is_read_q;
		reg_n     = reg_q;
		data_n    = data_q;
		recv_n    = recv_q;
		err_n     = err_q;
		do_adv    = 1'b0;
		do_after  = 1'b0;
		fin       = 1'b0;

		cmd = ((item.kind == KIND_WRITE) || (item.kind == KIND_READ)) && (step_q == STEP_IDLE);
		if (cmd) begin
			is_read_n = (item.kind == KIND_READ);
			reg_n     = item.reg_address;
			data_n    = item.write_data;
			err_n     = 1'b0;
			step_n    = STEP_START;
			dly_n     = 16'd0;
			cnt_n     = 8'd0;
		end
		cur_step = cmd ? STEP_START : step_q;
		lv = step_levels(cur_step, shift_q[7]);

		// tick: advance the waveform of the current step
		if ((item.kind == KIND_TICK) && (step_q != STEP_IDLE)) begin
			if (lv.units == 3'd0) begin
				// ack wait
				if (!item.sda_sampled) begin
					do_adv = 1'b1;
				end else begin
					cnt_n = cnt_inc;
					if (cnt_inc == cfg.ack_timeout) begin
						err_n    = 1'b1;
						do_after = 1'b1;
					end
				end
			end else begin
				if ((step_q == STEP_RX_SAMPLE) && (dly_q == 16'd0) && (cnt_q == 8'd0)) begin
					shift_n = {shift_q[6:0], item.sda_sampled};
				end
				if (dly_inc >= {1'b0, per_unit}) begin
					dly_n = 16'd0;
					cnt_n = cnt_inc;
					if (cnt_inc >= {5'd0, lv.units}) do_adv = 1'b1;
				end else begin
					dly_n = dly_inc[15:0];
				end
			end
		end

		if (do_adv) begin
			dly_n = 16'd0;
			cnt_n = 8'd0;
			case (stg_q)
				STG_START, STG_RESTART: begin
					if (seg_q == 3'd0) begin
						step_n = step_q + 6'd1;
					end else if (stg_q == STG_START) begin
						shift_n = cfg.device_address;
						bit_n   = 4'd0;
						step_n  = STEP_BYTE0;
					end else begin
						shift_n = cfg.device_address + 8'd1;
						bit_n   = 4'd0;
						step_n  = STEP_BYTE2;
					end
				end
				STG_BYTE0, STG_BYTE1, STG_BYTE2: begin
					if (seg_q == 3'd2) begin
						shift_n = {shift_q[6:0], 1'b0};
						bit_n   = bit_inc;
						step_n  = (bit_inc >= BITS_PER_BYTE) ? step_q + 6'd1 : step_q - 6'd2;
					end else if (seg_q == 3'd7) begin
						do_after = 1'b1;
					end else begin
						step_n = step_q + 6'd1;
					end
				end
				STG_RX: begin
					if (seg_q == 3'd2) begin
						bit_n = bit_inc;
						if (bit_inc >= BITS_PER_BYTE) begin
							recv_n = shift_n;
							step_n = STEP_STOP;
						end else begin
							step_n = step_q - 6'd1;
						end
					end else begin
						step_n = step_q + 6'd1;
					end
				end
				STG_STOP: begin
					if (seg_q >= 3'd2) begin
						step_n = STEP_IDLE;
						fin    = 1'b1;
					end else begin
						step_n = step_q + 6'd1;
					end
				end
				default: step_n = STEP_IDLE;
			endcase
		end

		// byte finished, by ack or by timeout
		if (do_after) begin
			dly_n = 16'd0;
			cnt_n = 8'd0;
			case (stg_q)
				STG_BYTE0: begin
					shift_n = reg_q;
					bit_n   = 4'd0;
					step_n  = STEP_BYTE1;
				end
				STG_BYTE1: begin
					if (is_read_q) begin
						step_n = STEP_RESTART;
					end else begin
						shift_n = data_q;
						bit_n   = 4'd0;
						step_n  = STEP_BYTE2;
					end
				end
				default: begin
					if (is_read_q) begin
						shift_n = 8'd0;
						bit_n   = 4'd0;
						step_n  = STEP_RX;
					end else begin
						step_n = STEP_STOP;
					end
				end
			endcase
		end

		res.scl_level    = lv.scl;
		res.sda_pull_low = lv.low;
		res.busy_res     = (step_n != STEP_IDLE);
		res.done_res     = fin;
		res.read_byte    = recv_n;
		res.ack_missing  = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_IDLE;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			dly_q     <= 16'd0;
			cnt_q     <= 8'd0;
			is_read_q <= 1'b0;
			reg_q     <= 8'd0;
			data_q    <= 8'd0;
			recv_q    <= 8'd0;
			err_q     <= 1'b0;
		end else if (step_en) begin
			step_q    <= step_n;
			bit_q     <= bit_n;
			shift_q   <= shift_n;
			dly_q     <= dly_n;
			cnt_q     <= cnt_n;
			is_read_q <= is_read_n;
			reg_q     <= reg_n;
			data_q    <= data_n;
			recv_q    <= recv_n;
			err_q     <= err_n;
		end
	end

endmodule
